### hw/rtl/osec_pkg.sv
// shared types and constants for the octal symbol encoder with check
// no dependencies
`default_nettype none

package osec_pkg;

  localparam int SYM_W        = 3;
  localparam int CHAR_W       = 6;
  localparam int MAX_SYMS     = 4;
  localparam int IDX_W        = 2;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [CHAR_W-1:0] CHAR_BASE = 6'd49;

  typedef logic [SYM_W-1:0] sym_t;

  // leftover count codes
  typedef enum logic [1:0] {
    LEFT_NONE  = 2'd0,
    LEFT_ONE   = 2'd1,
    LEFT_TWO   = 2'd2,
    LEFT_THREE = 2'd3
  } left_cnt_t;

  // symbols one byte produces, handed from front to back
  typedef struct packed {
    sym_t [MAX_SYMS-1:0] syms;
    logic [IDX_W-1:0]    last_idx;
    logic                last;
  } entry_t;

  function automatic logic [1:0] sym_ones(input sym_t s);
    logic [1:0] r;
    r = {1'b0, s[0]} + {1'b0, s[1]} + {1'b0, s[2]};
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/octal_symbol_encoder_with_check_core.sv
// octal symbol encoder with ones-count check symbol
// Bytes enter on the in_ channel (valid/stall), most significant bit first,
// with in_last_byte marking the end of a message. Each byte becomes two or
// three 3-bit symbols sent as ASCII '1'..'8' on the out_ channel, plus one
// check symbol on the last byte when bits are left over. out_run_end marks
// the last symbol of a byte, out_message_end the last symbol of a message.
// An accepted byte is written into the queue; its first symbol is loaded
// into the output register once it is at the head and the output is free.
// Throughput: while out_stall is low the output sends one symbol per cycle,
// so a byte yields two to four symbols; the front takes a byte per cycle
// while the queue between front and back has room, so in_stall rises only
// when QUEUE_DEPTH_P byte groups are waiting.
// Reset clears the leftover bits, the ones count, the queue pointers and the
// output valid flag and symbol index; no item is pending after reset.
// When out_stall is high the held symbol stays put, the queue fills, and
// then in_stall is raised; nothing is lost or repeated.
// depends on osec_pkg, osec_front, osec_queue, osec_back
`default_nettype none

module octal_symbol_encoder_with_check_core
  import osec_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_last_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [CHAR_W-1:0]      out_symbol_char,
  output logic                   out_run_end,
  output logic                   out_message_end
);

  entry_t new_entry, head;
  logic   push, pop, q_not_empty, q_full;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  osec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .entry     (new_entry)
  );

  osec_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (new_entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (q_not_empty),
    .full       (q_full)
  );

  osec_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .head_valid      (q_not_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_symbol_char (out_symbol_char),
    .out_run_end     (out_run_end),
    .out_message_end (out_message_end)
  );

endmodule

`default_nettype wire

### hw/rtl/osec_front.sv
// front end: takes bytes, cuts them into symbols, keeps leftover and ones count
// depends on osec_pkg
`default_nettype none

module osec_front
  import osec_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output entry_t          entry
);

  logic [1:0] left_bits_r, left_bits_nxt;
  left_cnt_t  left_cnt_r, left_cnt_nxt;
  logic [1:0] ones_r, ones_nxt;

  logic [9:0] acc;
  sym_t       s0, s1, s2;
  logic [1:0] tail;
  logic [1:0] rem;
  logic       three;
  logic [1:0] o0, o1, o2, ones_end;
  sym_t       chk;

  always_comb begin
    acc   = {left_bits_r, data_byte};
    s0    = '0;
    s1    = '0;
    s2    = '0;
    tail  = '0;
    rem   = 2'd0;
    three = 1'b1;
    unique case (left_cnt_r)
      LEFT_NONE: begin
        s0    = acc[7:5];
        s1    = acc[4:2];
        tail  = acc[1:0];
        rem   = 2'd2;
        three = 1'b0;
      end
      LEFT_ONE: begin
        s0 = acc[8:6];
        s1 = acc[5:3];
        s2 = acc[2:0];
      end
      LEFT_TWO: begin
        s0   = acc[9:7];
        s1   = acc[6:4];
        s2   = acc[3:1];
        tail = {1'b0, acc[0]};
        rem  = 2'd1;
      end
      LEFT_THREE: begin
        // unreachable count, ten bits read with the top symbol zero-padded
        s0   = {1'b0, acc[9:8]};
        s1   = acc[7:5];
        s2   = acc[4:2];
        tail = acc[1:0];
        rem  = 2'd2;
      end
      default: ;
    endcase

    o0       = ones_r + sym_ones(s0);
    o1       = o0 + sym_ones(s1);
    o2       = o1 + sym_ones(s2);
    ones_end = three ? o2 : o1;

    // leftover bits at the top, ones count in the free low bits
    if (rem == 2'd2) chk = {tail, ones_end[0]};
    else             chk = {tail[0], ones_end};

    entry.syms[0] = s0;
    entry.syms[1] = s1;
    entry.syms[2] = three ? s2 : chk;
    entry.syms[3] = chk;
    entry.last    = last_byte;
    if (last_byte && rem != 2'd0) entry.last_idx = three ? 2'd3 : 2'd2;
    else                          entry.last_idx = three ? 2'd2 : 2'd1;

    if (last_byte) begin
      left_bits_nxt = '0;
      left_cnt_nxt  = LEFT_NONE;
      ones_nxt      = '0;
    end else begin
      left_bits_nxt = tail;
      left_cnt_nxt  = left_cnt_t'(rem);
      ones_nxt      = ones_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_bits_r <= '0;
      left_cnt_r  <= LEFT_NONE;
      ones_r      <= '0;
    end else if (push) begin
      left_bits_r <= left_bits_nxt;
      left_cnt_r  <= left_cnt_nxt;
      ones_r      <= ones_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/osec_queue.sv
// short queue of symbol groups between front and back
// depends on osec_pkg; depth must be a power of two
`default_nettype none

module osec_queue
  import osec_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output entry_t      head,
  output logic        not_empty,
  output logic        full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t         mem [DEPTH];
  logic [PTR_W:0] wr_ptr_r, rd_ptr_r;

  assign not_empty = (wr_ptr_r != rd_ptr_r);
  assign full      = (wr_ptr_r[PTR_W] != rd_ptr_r[PTR_W]) &&
                     (wr_ptr_r[PTR_W-1:0] == rd_ptr_r[PTR_W-1:0]);
  assign head      = mem[rd_ptr_r[PTR_W-1:0]];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r[PTR_W-1:0]] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/osec_back.sv
// back end: sends the symbols of each queued group one per cycle while out_stall is low
// depends on osec_pkg
`default_nettype none

module osec_back
  import osec_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire entry_t            head,
  input  wire logic              head_valid,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [CHAR_W-1:0]      out_symbol_char,
  output logic                   out_run_end,
  output logic                   out_message_end
);

  logic [IDX_W-1:0]  idx_r;
  logic              valid_r;
  logic [CHAR_W-1:0] char_r;
  logic              run_end_r, msg_end_r;
  logic              load;
  logic              at_end;

  assign load   = head_valid && (!valid_r || !out_stall);
  assign at_end = (idx_r == head.last_idx);
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= at_end ? '0 : idx_r + 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r    <= CHAR_BASE + {{(CHAR_W-SYM_W){1'b0}}, head.syms[idx_r]};
      run_end_r <= at_end;
      msg_end_r <= at_end && head.last;
    end
  end

  assign out_valid       = valid_r;
  assign out_symbol_char = char_r;
  assign out_run_end     = run_end_r;
  assign out_message_end = msg_end_r;

endmodule

`default_nettype wire

### test/osec_checker.sv
// scoreboard for the octal symbol encoder: watches the byte and symbol channels,
// predicts the symbols of every accepted byte and compares them in order
// depends on osec_pkg
`timescale 1ns / 100ps

module osec_checker
  import osec_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_last_byte,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire logic [CHAR_W-1:0] out_symbol_char,
  input  wire logic              out_run_end,
  input  wire logic              out_message_end,
  output int                     fail_count,
  output int                     symbols_pending,
  output int                     symbols_checked,
  output int                     check_symbols
);

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              run_end;
    logic              msg_end;
  } symbol_rec_t;

  symbol_rec_t symbol_queue[$];

  // encoder state as the predictor sees it
  logic [1:0] carry_bits;
  left_cnt_t  carry_cnt;
  logic [1:0] ones_mod4;

  task automatic encode_byte(input logic [7:0] data, input logic last);
    logic [9:0]  bits;
    int          width;
    int          nsym;
    int          rem;
    logic [2:0]  sym;
    logic [1:0]  ones;
    logic [1:0]  tail;
    logic        has_check;
    logic        fin;
    symbol_rec_t rec;
    bits      = {carry_bits, data};
    width     = int'(carry_cnt) + 8;
    nsym      = width / SYM_W;
    rem       = width - nsym * SYM_W;
    ones      = ones_mod4;
    tail      = 2'(int'(bits) & ((1 << rem) - 1));
    has_check = last && (rem != 0);
    for (int k = 0; k < nsym; k++) begin
      sym  = 3'(bits >> (width - SYM_W * (k + 1)));
      ones = ones + 2'($countones(sym));
      fin  = (k + 1 == nsym) && !has_check;
      rec  = '{CHAR_BASE + CHAR_W'(sym), fin, fin && last};
      symbol_queue.push_back(rec);
    end
    if (last) begin
      if (has_check) begin
        // leftover bits on top, ones count in the free low bits
        if (rem == 2) sym = {tail, ones[0]};
        else          sym = {tail[0], ones};
        rec = '{CHAR_BASE + CHAR_W'(sym), 1'b1, 1'b1};
        symbol_queue.push_back(rec);
        check_symbols <= check_symbols + 1;
      end
      carry_bits = '0;
      carry_cnt  = LEFT_NONE;
      ones_mod4  = '0;
    end else begin
      carry_bits = tail;
      carry_cnt  = left_cnt_t'(rem);
      ones_mod4  = ones;
    end
  endtask

  initial begin
    fail_count      = 0;
    symbols_pending = 0;
    symbols_checked = 0;
    check_symbols   = 0;
    carry_bits      = '0;
    carry_cnt       = LEFT_NONE;
    ones_mod4       = '0;
  end

  always @(posedge clk) begin
    symbol_rec_t want;
    if (!rst_n) begin
      symbol_queue.delete();
      carry_bits = '0;
      carry_cnt  = LEFT_NONE;
      ones_mod4  = '0;
    end else begin
      if (in_valid && !in_stall) encode_byte(in_data_byte, in_last_byte);
      if (out_valid && !out_stall) begin
        if (symbol_queue.size() == 0) begin
          $display("%0t: unexpected symbol char=%0d run_end=%0b message_end=%0b",
                   $time, out_symbol_char, out_run_end, out_message_end);
          fail_count++;
        end else begin
          want = symbol_queue.pop_front();
          symbols_checked <= symbols_checked + 1;
          if (out_symbol_char !== want.char_code) begin
            $display("%0t: symbol_char expected %0d got %0d",
                     $time, want.char_code, out_symbol_char);
            fail_count++;
          end
          if (out_run_end !== want.run_end) begin
            $display("%0t: run_end expected %0b got %0b", $time, want.run_end, out_run_end);
            fail_count++;
          end
          if (out_message_end !== want.msg_end) begin
            $display("%0t: message_end expected %0b got %0b",
                     $time, want.msg_end, out_message_end);
            fail_count++;
          end
        end
      end
    end
    symbols_pending <= symbol_queue.size();
  end

endmodule

### test/tb_top.sv
// testbench top for octal_symbol_encoder_with_check_core: clock, reset, byte
// stimulus and output stall, verdict; checking lives in osec_checker
// depends on osec_pkg, osec_checker and the encoder rtl
`timescale 1ns / 100ps

module tb_top
  import osec_pkg::*;
;

  localparam int ITEM_TARGET = 260;
  localparam int PHASES      = 4;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_data_byte;
  logic              in_last_byte;
  logic              out_valid;
  logic              out_stall;
  logic [CHAR_W-1:0] out_symbol_char;
  logic              out_run_end;
  logic              out_message_end;

  int fail_count;
  int symbols_pending;
  int symbols_checked;
  int check_symbols;

  int send_idle_pct;
  int recv_stall_pct;
  int bytes_sent;
  int messages_sent;

  octal_symbol_encoder_with_check_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_symbol_char (out_symbol_char),
    .out_run_end     (out_run_end),
    .out_message_end (out_message_end)
  );

  osec_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_symbol_char (out_symbol_char),
    .out_run_end     (out_run_end),
    .out_message_end (out_message_end),
    .fail_count      (fail_count),
    .symbols_pending (symbols_pending),
    .symbols_checked (symbols_checked),
    .check_symbols   (check_symbols)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_400_000;
    $display("timeout with %0d symbols still expected", symbols_pending);
    $display("octal_symbol_encoder_with_check_core regression: fail");
    $finish;
  end

  // receiver stall, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_byte(input logic [7:0] data, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent++;
    if (last) messages_sent++;
  endtask

  task automatic send_message(input int len);
    logic [7:0] data;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0:       data = 8'h00;
        1:       data = 8'hFF;
        default: data = 8'($urandom);
      endcase
      send_byte(data, i == len - 1);
    end
  endtask

  initial begin
    int len;
    int phase_end;
    in_valid       = 1'b0;
    in_data_byte   = '0;
    in_last_byte   = 1'b0;
    out_stall      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    bytes_sent     = 0;
    messages_sent  = 0;
    rst_n          = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // one-byte messages: two bits left, check carries ones count mod 2
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b1);
    // two-byte messages: one bit left, check carries ones count mod 4
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    // three-byte messages end on a whole symbol, no check
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b1);
    // longer message wraps the leftover count more than once
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hC3, 1'b1);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      phase_end = (phase + 1) * (ITEM_TARGET / PHASES);
      while (bytes_sent < phase_end) begin
        len = ($urandom_range(4) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 5);
        send_message(len);
      end
    end
    in_valid <= 1'b0;

    while (symbols_pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("sent %0d bytes in %0d messages; %0d symbols compared, %0d of them check symbols",
             bytes_sent, messages_sent, symbols_checked, check_symbols);
    $display("sender idle and receiver stall mixes: none, 55/0, 0/55, 24/24 percent");
    if (fail_count == 0 && symbols_pending == 0) begin
      $display("octal_symbol_encoder_with_check_core regression: pass");
    end else begin
      $display("octal_symbol_encoder_with_check_core regression: fail");
    end
    $finish;
  end

endmodule
